[rtl/pit_pkg.sv]
// pit_pkg: shared types, mode codes and constants for the pomodoro interval timer
// used by pit_step and pomodoro_interval_timer; no dependencies
package pit_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_IDLE  = 2'd0;
  localparam mode_t MODE_FOCUS = 2'd1;
  localparam mode_t MODE_BREAK = 2'd2;
  localparam mode_t MODE_LONG  = 2'd3;

  localparam logic       OP_TICK     = 1'b0;
  localparam logic       OP_SET_MODE = 1'b1;

  localparam logic [6:0] IDLE_MINUTES  = 7'd25;
  localparam logic [6:0] FOCUS_DEFAULT = 7'd25;
  localparam logic [5:0] LAST_SECOND   = 6'd59;
  localparam logic [1:0] LAST_FOCUS    = 2'd3;

  typedef struct packed {
    mode_t      mode;
    logic [6:0] minutes;
    logic [5:0] seconds;
    logic [1:0] focus_cnt;
  } timer_state_t;

  typedef struct packed {
    logic [6:0] focus;
    logic [6:0] brk;
    logic [6:0] long_brk;
  } load_values_t;

  // floor(x / 5) for x below 384, by reciprocal multiply
  function automatic logic [6:0] div5(input logic [8:0] x);
    logic [16:0] prod;
    prod = {8'd0, x} * 17'd205;
    return prod[16:10];
  endfunction

  function automatic load_values_t make_loads(input logic [6:0] f);
    load_values_t lv;
    logic [8:0]   f3;
    f3          = {2'd0, f} + {1'd0, f, 1'b0};
    lv.focus    = f;
    lv.brk      = div5({2'd0, f});
    lv.long_brk = div5(f3);
    return lv;
  endfunction

endpackage

[rtl/pit_step.sv]
// pit_step: next timer state and chime for one word (tick or set-mode)
// depends on pit_pkg
module pit_step import pit_pkg::*; (
  input  timer_state_t cur,
  input  load_values_t loads,
  input  logic         op,
  input  mode_t        req,
  output timer_state_t nxt,
  output logic         chime
);

  function automatic logic [6:0] load_minutes(input mode_t m, input load_values_t lv);
    logic [6:0] r;
    case (m)
      MODE_IDLE:  r = IDLE_MINUTES;
      MODE_FOCUS: r = lv.focus;
      MODE_BREAK: r = lv.brk;
      MODE_LONG:  r = lv.long_brk;
      default:    r = IDLE_MINUTES;
    endcase
    return r;
  endfunction

  always_comb begin
    nxt   = cur;
    chime = 1'b0;
    if (op == OP_SET_MODE) begin
      if (req != cur.mode) begin
        nxt.mode    = req;
        nxt.minutes = load_minutes(req, loads);
        nxt.seconds = '0;
        chime       = 1'b1;
      end
    end else if (cur.mode != MODE_IDLE) begin
      if (cur.seconds != '0) begin
        nxt.seconds = cur.seconds - 6'd1;
      end else if (cur.minutes != '0) begin
        nxt.minutes = cur.minutes - 7'd1;
        nxt.seconds = LAST_SECOND;
      end else begin
        // period over
        if (cur.mode == MODE_FOCUS) begin
          if (cur.focus_cnt == LAST_FOCUS) begin
            nxt.focus_cnt = '0;
            nxt.mode      = MODE_LONG;
          end else begin
            nxt.focus_cnt = cur.focus_cnt + 2'd1;
            nxt.mode      = MODE_BREAK;
          end
        end else begin
          nxt.mode = MODE_FOCUS;
        end
        nxt.minutes = load_minutes(nxt.mode, loads);
        nxt.seconds = '0;
        chime       = 1'b1;
      end
    end
  end

endmodule

[rtl/pomodoro_interval_timer.sv]
// Pomodoro interval timer: modes idle, focus, break and long break with a
// minutes:seconds countdown and a count of finished focus periods. Each input
// word (a one-second tick or a set-mode request) produces one registered result
// word in the cycle after it is accepted; a new word is accepted every cycle while the
// result register is empty or being drained, so throughput is one word per cycle.
// The user must write focus_minutes through cfg_wen/cfg_wdata only while the
// block is idle; the block does not enforce this. Break lengths (F/5 and 3F/5)
// are computed and registered at that write; depends on pit_pkg and pit_step
module pomodoro_interval_timer import pit_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata,      // focus_minutes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] requested_mode, [7:2] zero
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [1:0] mode, [8:2] minutes_left,
                                      // [14:9] seconds_left, [15] chime,
                                      // [17:16] focus_done, [23:18] zero
);

  timer_state_t state, state_next;
  load_values_t loads;
  logic         chime;
  logic         in_fire;
  logic [23:0]  out_word;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = out_word;

  pit_step u_step (
    .cur   (state),
    .loads (loads),
    .op    (s_axis_tuser),
    .req   (s_axis_tdata[1:0]),
    .nxt   (state_next),
    .chime (chime)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      loads <= make_loads(FOCUS_DEFAULT);
    end else if (cfg_wen) begin
      loads <= make_loads(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode      <= MODE_IDLE;
      state.minutes   <= IDLE_MINUTES;
      state.seconds   <= '0;
      state.focus_cnt <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (in_fire) begin
        state <= state_next;
      end
      if (in_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word <= {6'd0, state_next.focus_cnt, chime, state_next.seconds,
                   state_next.minutes, state_next.mode};
    end
  end

  a_seconds_range: assert property (@(posedge clk) disable iff (rst)
    state.seconds <= LAST_SECOND)
    else $error("second count above 59");

  a_chime_reload: assert property (@(posedge clk) disable iff (rst)
    in_fire && chime |=> state.seconds == '0 && m_axis_tdata[15])
    else $error("mode entry without countdown reload");

  a_idle_tick_hold: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_axis_tuser == OP_TICK && state.mode == MODE_IDLE |=> $stable(state))
    else $error("tick changed state in idle");

  a_idle_minutes: assert property (@(posedge clk) disable iff (rst)
    in_fire && chime && state_next.mode == MODE_IDLE |=> state.minutes == IDLE_MINUTES)
    else $error("idle entered with wrong countdown");

endmodule

[verif/tb_pomodoro_interval_timer.sv]
// tb_pomodoro_interval_timer: self-checking testbench for the pomodoro interval timer
// predicts every result word in-line and checks each one as it leaves the block
// depends on pit_pkg and the pomodoro_interval_timer rtl
module tb_pomodoro_interval_timer;
  timeunit 1ns;
  timeprecision 1ps;
  import pit_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    mode_t      mode;
    logic [6:0] minutes;
    logic [5:0] seconds;
    logic       chime;
    logic [1:0] focus_done;
  } timer_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // [1:0] requested_mode, [7:2] zero
  logic        s_axis_tuser = 1'b0; // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [1:0] mode, [8:2] minutes_left, [14:9] seconds_left,
                                    // [15] chime, [17:16] focus_done, [23:18] zero

  // timer state as the block should hold it
  mode_t      cur_mode;
  logic [6:0] minutes_left;
  logic [5:0] seconds_left;
  logic [2:0] focus_count;
  logic [6:0] focus_min;

  timer_word_t expected_words[$];
  int          mismatches = 0;
  int          words_checked = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  pomodoro_interval_timer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [6:0] load_minutes(mode_t m);
    int         f;
    logic [6:0] r;
    f = int'(focus_min);
    case (m)
      MODE_IDLE:  r = IDLE_MINUTES;
      MODE_FOCUS: r = focus_min;
      MODE_BREAK: r = 7'(f / 5);
      default:    r = 7'((3 * f) / 5);
    endcase
    return r;
  endfunction

  function automatic void enter_mode(mode_t m);
    cur_mode     = m;
    minutes_left = load_minutes(m);
    seconds_left = '0;
  endfunction

  function automatic timer_word_t step_timer(logic op, mode_t req);
    timer_word_t w;
    logic        chime;
    chime = 1'b0;
    if (op == OP_SET_MODE) begin
      if (req != cur_mode) begin
        enter_mode(req);
        chime = 1'b1;
      end
    end else if (cur_mode != MODE_IDLE) begin
      if (seconds_left != '0) begin
        seconds_left = seconds_left - 6'd1;
      end else if (minutes_left != '0) begin
        minutes_left = minutes_left - 7'd1;
        seconds_left = LAST_SECOND;
      end else begin
        if (cur_mode == MODE_FOCUS) begin
          focus_count = focus_count + 3'd1;
          if (focus_count > {1'b0, LAST_FOCUS}) begin
            focus_count = '0;
            enter_mode(MODE_LONG);
          end else begin
            enter_mode(MODE_BREAK);
          end
        end else begin
          enter_mode(MODE_FOCUS);
        end
        chime = 1'b1;
      end
    end
    w.mode       = cur_mode;
    w.minutes    = minutes_left;
    w.seconds    = seconds_left;
    w.chime      = chime;
    w.focus_done = focus_count[1:0];
    return w;
  endfunction

  task automatic send_word(logic op, mode_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, req};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_words.push_back(step_timer(op, req));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_focus(logic [6:0] value);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    focus_min = value;
    @(posedge clk);
  endtask

  task automatic test_idle_behavior();
    send_word(OP_TICK, MODE_LONG);
    send_word(OP_TICK, MODE_FOCUS);
    send_word(OP_SET_MODE, MODE_IDLE);
  endtask

  task automatic test_mode_requests();
    send_word(OP_SET_MODE, MODE_FOCUS);
    send_word(OP_TICK, MODE_BREAK);
    send_word(OP_SET_MODE, MODE_FOCUS);
    send_word(OP_SET_MODE, MODE_BREAK);
    send_word(OP_SET_MODE, MODE_LONG);
    send_word(OP_SET_MODE, MODE_LONG);
    send_word(OP_SET_MODE, MODE_IDLE);
  endtask

  // zero-length periods: every tick ends one, four focus ends reach long break
  task automatic test_period_rollover();
    write_focus(7'd0);
    send_word(OP_SET_MODE, MODE_FOCUS);
    repeat (9) send_word(OP_TICK, mode_t'($urandom_range(3)));
    send_word(OP_SET_MODE, MODE_IDLE);
  endtask

  task automatic test_focus_extremes();
    write_focus(7'd127);
    send_word(OP_SET_MODE, MODE_LONG);
    send_word(OP_SET_MODE, MODE_BREAK);
    send_word(OP_SET_MODE, MODE_FOCUS);
    send_word(OP_TICK, MODE_IDLE);
  endtask

  task automatic test_random_traffic(int blocks, int words_per_block);
    int f;
    for (int b = 0; b < blocks; b++) begin
      case ($urandom_range(9))
        0, 1:    f = 0;
        2, 3:    f = 1;
        4:       f = 2;
        5:       f = 3;
        6:       f = $urandom_range(10, 4);
        7:       f = 99;
        8:       f = 127;
        default: f = $urandom_range(127);
      endcase
      write_focus(f[6:0]);
      for (int k = 0; k < words_per_block; k++) begin
        if ($urandom_range(99) < 6)
          send_word(OP_SET_MODE, mode_t'($urandom_range(3)));
        else
          send_word(OP_TICK, mode_t'($urandom_range(3)));
      end
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    timer_word_t got;
    timer_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.mode       = m_axis_tdata[1:0];
      got.minutes    = m_axis_tdata[8:2];
      got.seconds    = m_axis_tdata[14:9];
      got.chime      = m_axis_tdata[15];
      got.focus_done = m_axis_tdata[17:16];
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: unexpected result %h", words_checked, m_axis_tdata);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"word %0d: expected mode %0d %0d:%0d chime %0b done %0d, ",
                      "got mode %0d %0d:%0d chime %0b done %0d"},
                     words_checked, want.mode, want.minutes, want.seconds, want.chime,
                     want.focus_done, got.mode, got.minutes, got.seconds, got.chime,
                     got.focus_done);
        end
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cur_mode     = MODE_IDLE;
    minutes_left = IDLE_MINUTES;
    seconds_left = '0;
    focus_count  = '0;
    focus_min    = FOCUS_DEFAULT;
    send_idle_pct = 9;
    recv_idle_pct = 85;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_behavior();
    test_mode_requests();
    test_period_rollover();
    test_focus_extremes();

    test_random_traffic(4, 120);
    wait_idle();
    send_idle_pct = 85;
    recv_idle_pct = 9;
    test_random_traffic(4, 120);
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(4, 120);

    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_words.size() != 0) begin
      mismatches++;
      $display("%0d expected words never arrived", expected_words.size());
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
